// ===== hdl/bmprle8_pkg.sv =====
// Package for the bitmap RLE8 decoder: shared widths, result kind codes,
// register indexes, stream codes and the default address width and queue depth.
// No dependencies.
package bmprle8_pkg;

    // Field widths fixed by the stream format and the register map
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 8;
    localparam int FRAME_W     = 25;
    localparam int STREAM_W    = 25;
    localparam int STRIDE_W    = 16;
    localparam int KIND_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 25;

    // Defaults for top level parameters
    localparam int ADDR_WIDTH_DEFAULT = 24;
    localparam int QUEUE_DEPTH        = 2;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_PIXEL = 2'd0,
        KIND_END   = 2'd1,
        KIND_STOP  = 2'd2
    } kind_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_PIXELS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STREAM_BYTES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_STRIDE  = 2'd2;

    // Stream codes: a zero code byte opens an escape
    localparam logic [BYTE_W-1:0] CODE_ESCAPE = 8'h00;
    localparam logic [BYTE_W-1:0] ESC_EOL     = 8'h00;
    localparam logic [BYTE_W-1:0] ESC_END     = 8'h01;
    localparam logic [BYTE_W-1:0] ESC_DELTA   = 8'h02;

endpackage

// ===== hdl/bmprle8_front.sv =====
// Front end of the RLE8 decoder: parses one stream byte per cycle while s_ready
// is high, keeps the stream and frame positions and produces one packed write
// command per result. Depends on bmprle8_pkg.
module bmprle8_front #(
    parameter int ADDR_WIDTH = bmprle8_pkg::ADDR_WIDTH_DEFAULT,
    parameter int CMD_W      = ADDR_WIDTH + 18
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // byte channel
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [bmprle8_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic                              s_stream_start,
    // configuration
    input  logic [bmprle8_pkg::FRAME_W-1:0]   frame_pixels,
    input  logic [bmprle8_pkg::STREAM_W-1:0]  stream_bytes,
    input  logic [bmprle8_pkg::STRIDE_W-1:0]  line_stride,
    // command to the queue: {kind, addr, count, value}
    output logic                              push,
    output logic [CMD_W-1:0]                  push_data
);

    // Positions hold frame offsets plus one delta step and one stride
    localparam int POS_W = ((ADDR_WIDTH > bmprle8_pkg::FRAME_W) ?
                            ADDR_WIDTH : bmprle8_pkg::FRAME_W) + 2;
    localparam int IN_W  = bmprle8_pkg::STREAM_W + 1;
    localparam int DY_W  = bmprle8_pkg::BYTE_W + bmprle8_pkg::STRIDE_W;
    localparam int CW    = bmprle8_pkg::COUNT_W;
    localparam int BW    = bmprle8_pkg::BYTE_W;

    typedef enum logic [7:0] {
        PH_CODE   = 8'b0000_0001,
        PH_RUNVAL = 8'b0000_0010,
        PH_ESC    = 8'b0000_0100,
        PH_DX     = 8'b0000_1000,
        PH_DY     = 8'b0001_0000,
        PH_LIT    = 8'b0010_0000,
        PH_PAD    = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } phase_t;

    phase_t                  phase_reg, phase_next, phase_cur;
    logic [IN_W-1:0]         in_reg, in_next, in_cur, in_inc;
    logic [POS_W-1:0]        out_reg, out_next, out_cur;
    logic [POS_W-1:0]        lsn_reg, lsn_next, lsn_cur;
    logic [CW-1:0]           hc_reg, hc_next, hc_cur, hc_dec, run_n;
    logic [BW-1:0]           hdx_reg, hdx_next, hdx_cur;

    logic                    fire;
    logic [POS_W-1:0]        frame_cap, frame_ext, frame;
    logic [IN_W-1:0]         total;
    logic [DY_W-1:0]         dy;
    bmprle8_pkg::kind_t      cmd_kind;
    logic [ADDR_WIDTH-1:0]   cmd_addr;
    logic [CW-1:0]           cmd_count;

    assign fire = s_valid && s_ready;

    // Frame size, capped at the address space
    assign frame_cap = POS_W'(1) << ADDR_WIDTH;
    assign frame_ext = POS_W'(frame_pixels);
    assign frame     = (frame_ext > frame_cap) ? frame_cap : frame_ext;
    assign total     = IN_W'(stream_bytes);

    // Delta line offset
    assign dy = DY_W'(s_data_byte) * DY_W'(line_stride);

    // State seen by this byte: a stream start restarts all positions
    always_comb begin
        if (s_stream_start) begin
            phase_cur = PH_CODE;
            in_cur    = '0;
            out_cur   = '0;
            lsn_cur   = POS_W'(line_stride);
            hc_cur    = '0;
            hdx_cur   = '0;
        end else begin
            phase_cur = phase_reg;
            in_cur    = in_reg;
            out_cur   = out_reg;
            lsn_cur   = lsn_reg;
            hc_cur    = hc_reg;
            hdx_cur   = hdx_reg;
        end
    end

    assign in_inc = in_cur + IN_W'(1);
    assign hc_dec = (hc_cur != '0) ? hc_cur - CW'(1) : hc_cur;

    // Encoded run length, clipped at the frame end
    always_comb begin
        if ((out_cur + POS_W'(s_data_byte)) > frame) begin
            run_n = CW'(frame - out_cur);
        end else begin
            run_n = s_data_byte;
        end
    end

    // Byte parser
    always_comb begin
        phase_next = phase_cur;
        in_next    = in_cur;
        out_next   = out_cur;
        lsn_next   = lsn_cur;
        hc_next    = hc_cur;
        hdx_next   = hdx_cur;
        push       = 1'b0;
        cmd_kind   = bmprle8_pkg::KIND_PIXEL;
        cmd_addr   = out_cur[ADDR_WIDTH-1:0];
        cmd_count  = CW'(1);
        case (phase_cur)
            PH_CODE: begin
                if (out_cur >= frame || (in_cur + IN_W'(2)) > total) begin
                    phase_next = PH_DONE;
                    push       = fire;
                    cmd_kind   = bmprle8_pkg::KIND_STOP;
                end else begin
                    in_next = in_inc;
                    if (s_data_byte != bmprle8_pkg::CODE_ESCAPE) begin
                        hc_next    = run_n;
                        phase_next = PH_RUNVAL;
                    end else begin
                        phase_next = PH_ESC;
                    end
                end
            end
            PH_RUNVAL: begin
                in_next    = in_inc;
                out_next   = out_cur + POS_W'(hc_cur);
                phase_next = PH_CODE;
                push       = fire;
                cmd_count  = hc_cur;
            end
            PH_ESC: begin
                in_next = in_inc;
                if (s_data_byte == bmprle8_pkg::ESC_EOL) begin
                    out_next   = lsn_cur;
                    lsn_next   = lsn_cur + POS_W'(line_stride);
                    phase_next = PH_CODE;
                end else if (s_data_byte == bmprle8_pkg::ESC_END) begin
                    phase_next = PH_DONE;
                    push       = fire;
                    cmd_kind   = bmprle8_pkg::KIND_END;
                end else if (s_data_byte == bmprle8_pkg::ESC_DELTA) begin
                    if ((in_inc + IN_W'(2)) > total) begin
                        phase_next = PH_DONE;
                        push       = fire;
                        cmd_kind   = bmprle8_pkg::KIND_STOP;
                    end else begin
                        phase_next = PH_DX;
                    end
                end else if ((in_inc + IN_W'(s_data_byte)) > total ||
                             (out_cur + POS_W'(s_data_byte)) > frame) begin
                    // literal would overrun the stream or the frame
                    phase_next = PH_DONE;
                    push       = fire;
                    cmd_kind   = bmprle8_pkg::KIND_STOP;
                end else begin
                    hc_next    = s_data_byte;
                    hdx_next   = s_data_byte;
                    phase_next = PH_LIT;
                end
            end
            PH_DX: begin
                in_next    = in_inc;
                hdx_next   = s_data_byte;
                phase_next = PH_DY;
            end
            PH_DY: begin
                in_next    = in_inc;
                out_next   = out_cur + POS_W'(hdx_cur) + POS_W'(dy);
                lsn_next   = lsn_cur + POS_W'(dy);
                hdx_next   = '0;
                phase_next = PH_CODE;
            end
            PH_LIT: begin
                in_next  = in_inc;
                out_next = out_cur + POS_W'(1);
                hc_next  = hc_dec;
                if (hc_dec == '0) begin
                    phase_next = hdx_cur[0] ? PH_PAD : PH_CODE;
                end
                push      = fire;
                cmd_count = CW'(1);
            end
            PH_PAD: begin
                in_next    = in_inc;
                phase_next = PH_CODE;
            end
            PH_DONE: begin
                push = 1'b0;
            end
            default: begin
                phase_next = PH_CODE;
            end
        endcase
    end

    assign push_data = {cmd_kind, cmd_addr, cmd_count, s_data_byte};

    // State registers, updated on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CODE;
            in_reg    <= '0;
            out_reg   <= '0;
            lsn_reg   <= '0;
            hc_reg    <= '0;
            hdx_reg   <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            in_reg    <= in_next;
            out_reg   <= out_next;
            lsn_reg   <= lsn_next;
            hc_reg    <= hc_next;
            hdx_reg   <= hdx_next;
        end
    end

    // A finished stream stays silent until the next stream start
    a_done_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !s_stream_start && phase_reg == PH_DONE) |-> !push)
        else $error("front: result after end of stream");

    // End and stop reports always close the stream
    a_report_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && cmd_kind != bmprle8_pkg::KIND_PIXEL) |=> (phase_reg == PH_DONE))
        else $error("front: stream not closed after end or stop");

    // Every literal byte gives a single pixel write
    a_literal_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !s_stream_start && phase_reg == PH_LIT) |->
        (push && cmd_kind == bmprle8_pkg::KIND_PIXEL && cmd_count == CW'(1)))
        else $error("front: literal byte without one-pixel write");

endmodule

// ===== hdl/bmprle8_queue.sv =====
// Small command queue between the decoder front end and the output stage.
// Register based, DEPTH of at least 2. Depends on bmprle8_pkg for defaults.
module bmprle8_queue #(
    parameter int DEPTH  = bmprle8_pkg::QUEUE_DEPTH,
    parameter int DATA_W = bmprle8_pkg::ADDR_WIDTH_DEFAULT + 18
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output logic [DATA_W-1:0] q_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // Pointer wrap and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The front end must never write into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue: write while full");

    // Occupancy stays within the storage
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue: count out of range");

    // An empty queue becomes non-empty only through a write
    a_fill_by_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 && !push) |=> (count_reg == '0))
        else $error("queue: entry appeared without a write");

endmodule

// ===== hdl/bmprle8_back.sv =====
// Output stage of the RLE8 decoder: takes commands from the queue, formats
// the result fields and holds them in a register for the result channel.
// Depends on bmprle8_pkg.
module bmprle8_back #(
    parameter int ADDR_WIDTH = bmprle8_pkg::ADDR_WIDTH_DEFAULT,
    parameter int CMD_W      = ADDR_WIDTH + 18
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  logic [CMD_W-1:0]                 q_data,
    output logic                             pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bmprle8_pkg::KIND_W-1:0]   m_kind,
    output logic [ADDR_WIDTH-1:0]            m_write_addr,
    output logic [bmprle8_pkg::COUNT_W-1:0]  m_write_count,
    output logic [bmprle8_pkg::BYTE_W-1:0]   m_pixel_value
);

    localparam int CW = bmprle8_pkg::COUNT_W;
    localparam int BW = bmprle8_pkg::BYTE_W;

    bmprle8_pkg::kind_t     cmd_kind;
    logic [ADDR_WIDTH-1:0]  cmd_addr;
    logic [CW-1:0]          cmd_count;
    logic [BW-1:0]          cmd_value;
    logic                   is_pixel;

    logic                   valid_reg, valid_next;
    bmprle8_pkg::kind_t     kind_reg;
    logic [ADDR_WIDTH-1:0]  addr_reg;
    logic [CW-1:0]          count_reg;
    logic [BW-1:0]          value_reg;

    // Unpack {kind, addr, count, value}
    assign cmd_kind  = bmprle8_pkg::kind_t'(q_data[CMD_W-1 -: bmprle8_pkg::KIND_W]);
    assign cmd_addr  = q_data[CW+BW +: ADDR_WIDTH];
    assign cmd_count = q_data[BW +: CW];
    assign cmd_value = q_data[BW-1:0];
    assign is_pixel  = (cmd_kind == bmprle8_pkg::KIND_PIXEL);

    // Load when the output register is free or being emptied
    assign pop = q_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Result fields: end and stop reports carry zeros
    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg  <= cmd_kind;
            addr_reg  <= is_pixel ? cmd_addr : '0;
            count_reg <= is_pixel ? cmd_count : '0;
            value_reg <= is_pixel ? cmd_value : '0;
        end
    end

    assign m_valid       = valid_reg;
    assign m_kind        = kind_reg;
    assign m_write_addr  = addr_reg;
    assign m_write_count = count_reg;
    assign m_pixel_value = value_reg;

endmodule

// ===== hdl/bmp_rle8_decoder.sv =====
// Top level of the bitmap RLE8 decoder: configuration registers, front end
// parser, command queue and output stage.
// Depends on bmprle8_pkg, bmprle8_front, bmprle8_queue, bmprle8_back.
//
//  channel   ports                                   direction  width
//  s_        s_data_byte, s_stream_start             in         8, 1
//  m_        m_kind, m_write_addr, m_write_count,    out        2, ADDR_WIDTH,
//            m_pixel_value                                      8, 8
//  cfg_      cfg_index, cfg_data                     in         2, 25
//
// One stream byte is taken per cycle while s_ready is high; the parser finishes
// each byte in the cycle it is accepted, so the rate is one byte per clock.
// A result is written into the queue by the edge that accepts its byte and
// moves into the output register once that register is free or being emptied.
// s_ready drops only while the queue is full, which a stall on m_ can cause;
// cfg_ is always ready.
// Reset returns the parser to the code phase with cleared positions and clears all configuration registers to zero.
module bmp_rle8_decoder #(
    parameter int ADDR_WIDTH = bmprle8_pkg::ADDR_WIDTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [bmprle8_pkg::BYTE_W-1:0]       s_data_byte,
    input  logic                                 s_stream_start,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [bmprle8_pkg::KIND_W-1:0]       m_kind,
    output logic [ADDR_WIDTH-1:0]                m_write_addr,
    output logic [bmprle8_pkg::COUNT_W-1:0]      m_write_count,
    output logic [bmprle8_pkg::BYTE_W-1:0]       m_pixel_value,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bmprle8_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bmprle8_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CMD_W = ADDR_WIDTH + 18;

    logic [bmprle8_pkg::FRAME_W-1:0]   frame_pixels_reg;
    logic [bmprle8_pkg::STREAM_W-1:0]  stream_bytes_reg;
    logic [bmprle8_pkg::STRIDE_W-1:0]  line_stride_reg;
    logic                              cfg_fire;

    logic              push, full, pop, q_valid;
    logic [CMD_W-1:0]  push_data, q_data;

    // Configuration registers
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pixels_reg <= '0;
            stream_bytes_reg <= '0;
            line_stride_reg  <= '0;
        end else if (cfg_fire) begin
            case (cfg_index)
                bmprle8_pkg::REG_FRAME_PIXELS: begin
                    frame_pixels_reg <= cfg_data[bmprle8_pkg::FRAME_W-1:0];
                end
                bmprle8_pkg::REG_STREAM_BYTES: begin
                    stream_bytes_reg <= cfg_data[bmprle8_pkg::STREAM_W-1:0];
                end
                bmprle8_pkg::REG_LINE_STRIDE: begin
                    line_stride_reg <= cfg_data[bmprle8_pkg::STRIDE_W-1:0];
                end
                default: begin
                    frame_pixels_reg <= frame_pixels_reg;
                end
            endcase
        end
    end

    // Bytes are taken whenever the queue has room
    assign s_ready = !full;

    bmprle8_front #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .CMD_W      (CMD_W)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_stream_start (s_stream_start),
        .frame_pixels   (frame_pixels_reg),
        .stream_bytes   (stream_bytes_reg),
        .line_stride    (line_stride_reg),
        .push           (push),
        .push_data      (push_data)
    );

    bmprle8_queue #(
        .DEPTH  (bmprle8_pkg::QUEUE_DEPTH),
        .DATA_W (CMD_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    bmprle8_back #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .CMD_W      (CMD_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_write_addr  (m_write_addr),
        .m_write_count (m_write_count),
        .m_pixel_value (m_pixel_value)
    );

endmodule
